[hdl/adsr_linear_envelope_core_macros.svh]
// Assertion helpers shared by the envelope core files.
`ifndef ADSR_LINEAR_ENVELOPE_CORE_MACROS_SVH
`define ADSR_LINEAR_ENVELOPE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ADSR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("envelope core: same-cycle check failed");

// Next-cycle implication.
`define ADSR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("envelope core: next-cycle check failed");

`endif

[hdl/adsr_le_pkg.sv]
package adsr_le_pkg;

  localparam int LEVEL_W          = 10;
  localparam int END_W            = 16;
  localparam int PROD_W           = LEVEL_W + END_W;
  localparam int CNT_W            = $clog2(LEVEL_W);
  localparam int MINUTE_WIDTH_DEF = 16;
  localparam int CFG_ADDR_W       = 5;
  localparam int CFG_DATA_W       = 32;
  localparam int REG_ADDR_LSB     = 2;
  localparam int SEG_W            = 3;

  typedef enum logic [2:0] {
    REG_ATTACK_END,
    REG_DECAY_END,
    REG_SUSTAIN_END,
    REG_RELEASE_END,
    REG_PEAK_LEVEL,
    REG_SUSTAIN_LEVEL,
    REG_ENVELOPE_ON
  } reg_idx_e;

  typedef enum logic [SEG_W-1:0] {
    SEG_ATTACK,
    SEG_DECAY,
    SEG_SUSTAIN,
    SEG_RELEASE,
    SEG_FINISHED
  } seg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_CALC,
    ST_OUT
  } core_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  typedef struct packed {
    logic [END_W-1:0]   attack_end;
    logic [END_W-1:0]   decay_end;
    logic [END_W-1:0]   sustain_end;
    logic [END_W-1:0]   release_end;
    logic [LEVEL_W-1:0] peak_level;
    logic [LEVEL_W-1:0] sustain_level;
    logic               envelope_on;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    attack_end:    '0,
    decay_end:     '0,
    sustain_end:   '0,
    release_end:   '0,
    peak_level:    '0,
    sustain_level: '0,
    envelope_on:   1'b1
  };

  // Request to the serial scale unit: q = a * n / d, with n <= d.
  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] a;
    logic [END_W-1:0]   n;
    logic [END_W-1:0]   d;
  } md_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] q;
  } md_rsp_t;

endpackage

[hdl/adsr_le_muldiv.sv]
`include "adsr_linear_envelope_core_macros.svh"

module adsr_le_muldiv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  adsr_le_pkg::md_req_t req_i,
  output adsr_le_pkg::md_rsp_t rsp_o
);
  import adsr_le_pkg::*;

  md_state_e          state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [PROD_W-1:0]  acc_q, acc_d;
  logic [LEVEL_W-1:0] a_q, a_d;
  logic [END_W-1:0]   n_q, n_d;
  logic [END_W-1:0]   d_q, d_d;

  logic [END_W:0]     trial;
  logic [END_W:0]     rem;
  logic               ge;

  // Division works on the accumulator in place: the partial remainder sits in
  // the upper bits, the product's low bits shift out at the top of the lower
  // field while quotient bits shift in at the bottom.
  assign trial = {acc_q[PROD_W-1:LEVEL_W], acc_q[LEVEL_W-1]};
  assign ge    = trial >= {1'b0, d_q};
  assign rem   = ge ? trial - {1'b0, d_q} : trial;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    a_d     = a_q;
    n_d     = n_q;
    d_d     = d_q;
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.a;
          n_d     = req_i.n;
          d_d     = req_i.d;
          acc_d   = '0;
          cnt_d   = CNT_W'(LEVEL_W - 1);
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        // One multiplier bit per cycle, most significant first.
        acc_d = {acc_q[PROD_W-2:0], 1'b0} + (a_q[LEVEL_W-1] ? PROD_W'(n_q) : '0);
        a_d   = {a_q[LEVEL_W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CNT_W'(LEVEL_W - 1);
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        // Since n <= d the quotient fits LEVEL_W bits, so the upper product
        // field already lies below d and only LEVEL_W steps are needed.
        acc_d = {rem[END_W-1:0], acc_q[LEVEL_W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = MD_IDLE;
        end
      end
      default: begin
        state_d = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    n_q   <= n_d;
    d_q   <= d_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = acc_q[LEVEL_W-1:0];

  `ADSR_ASSERT_NXT(a_md_start_busy, clk_i, rst_ni, req_i.start && state_q == MD_IDLE, state_q == MD_MUL)
  `ADSR_ASSERT_IMP(a_md_done_idle, clk_i, rst_ni, done_q, state_q == MD_IDLE)

endmodule

[hdl/adsr_le_cfg.sv]
module adsr_le_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [adsr_le_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [adsr_le_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [adsr_le_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                pready,
  output adsr_le_pkg::cfg_t                   cfg_o
);
  import adsr_le_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:REG_ADDR_LSB]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_ATTACK_END:    cfg_d.attack_end    = pwdata[END_W-1:0];
        REG_DECAY_END:     cfg_d.decay_end     = pwdata[END_W-1:0];
        REG_SUSTAIN_END:   cfg_d.sustain_end   = pwdata[END_W-1:0];
        REG_RELEASE_END:   cfg_d.release_end   = pwdata[END_W-1:0];
        REG_PEAK_LEVEL:    cfg_d.peak_level    = pwdata[LEVEL_W-1:0];
        REG_SUSTAIN_LEVEL: cfg_d.sustain_level = pwdata[LEVEL_W-1:0];
        REG_ENVELOPE_ON:   cfg_d.envelope_on   = pwdata[0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ATTACK_END:    prdata = CFG_DATA_W'(cfg_q.attack_end);
      REG_DECAY_END:     prdata = CFG_DATA_W'(cfg_q.decay_end);
      REG_SUSTAIN_END:   prdata = CFG_DATA_W'(cfg_q.sustain_end);
      REG_RELEASE_END:   prdata = CFG_DATA_W'(cfg_q.release_end);
      REG_PEAK_LEVEL:    prdata = CFG_DATA_W'(cfg_q.peak_level);
      REG_SUSTAIN_LEVEL: prdata = CFG_DATA_W'(cfg_q.sustain_level);
      REG_ENVELOPE_ON:   prdata = CFG_DATA_W'(cfg_q.envelope_on);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/adsr_linear_envelope_core.sv]
// Linear ADSR envelope generator. Each input beat is one minute tick or a
// restart, and each produces exactly one output beat with the level, the
// minute counter, the segment code and the sticky finished flag. A restart
// goes from idle straight to the output state, which loads the output
// register; a tick first passes the segment state, which settles the level
// for a tick in sustain, after the envelope finished or while switched off.
// A tick on a nonzero-length attack, decay or release ramp then waits in the
// calc state for a scale-by-ratio worked out by one shared bit-serial unit,
// ten shift-add multiply steps followed by ten restoring divide steps. The
// next beat is accepted in the cycle after the output register loads. The
// output register lets the next beat be accepted while a result still waits
// downstream; a result that finds the output register still full holds the
// block until it drains. Registers sit on an APB-style port at byte address
// 4*index and should only be written while no beat is in flight.
`include "adsr_linear_envelope_core_macros.svh"

module adsr_linear_envelope_core #(
  parameter int MinuteWidth = adsr_le_pkg::MINUTE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [adsr_le_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [adsr_le_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [adsr_le_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [adsr_le_pkg::LEVEL_W-1:0]     level_o,
  output logic [adsr_le_pkg::END_W-1:0]       minute_now_o,
  output logic [adsr_le_pkg::SEG_W-1:0]       segment_o,
  output logic                                finished_o
);
  import adsr_le_pkg::*;

  localparam int CmpW = (MinuteWidth > END_W) ? MinuteWidth : END_W;

  cfg_t    cfg;
  md_req_t md_req;
  md_rsp_t md_rsp;
  logic    md_start;

  core_state_e          state_q, state_d;
  logic [MinuteWidth-1:0] minute_q, minute_d;
  logic [LEVEL_W-1:0]   level_q, level_d;
  logic                 done_q, done_d;
  seg_e                 rseg_q, rseg_d;
  logic [LEVEL_W-1:0]   base_q, base_d;
  logic                 sub_q, sub_d;

  logic                 out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]   out_level_q, out_level_d;
  logic [END_W-1:0]     out_minute_q, out_minute_d;
  seg_e                 out_seg_q, out_seg_d;
  logic                 out_fin_q, out_fin_d;

  logic [CmpW-1:0]      minute_ext;
  logic [CmpW-1:0]      seg_start;
  seg_e                 seg_raw;
  logic [LEVEL_W-1:0]   seg_a;
  logic [LEVEL_W-1:0]   seg_base;
  logic                 seg_sub;
  logic [END_W-1:0]     seg_num;
  logic [END_W-1:0]     seg_den;
  logic [CmpW-1:0]      num_full;

  adsr_le_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  adsr_le_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign minute_ext = CmpW'(minute_q);

  // First segment whose end the minute has not passed.
  always_comb begin
    if (minute_ext <= CmpW'(cfg.attack_end)) begin
      seg_raw = SEG_ATTACK;
    end else if (minute_ext <= CmpW'(cfg.decay_end)) begin
      seg_raw = SEG_DECAY;
    end else if (minute_ext <= CmpW'(cfg.sustain_end)) begin
      seg_raw = SEG_SUSTAIN;
    end else if (minute_ext <= CmpW'(cfg.release_end)) begin
      seg_raw = SEG_RELEASE;
    end else begin
      seg_raw = SEG_FINISHED;
    end
  end

  // Ramp set-up: level = base -/+ a * (m - start) / den.
  always_comb begin
    case (seg_raw)
      SEG_ATTACK: begin
        seg_start = '0;
        seg_den   = cfg.attack_end;
        seg_base  = '0;
        seg_sub   = 1'b0;
        seg_a     = cfg.peak_level;
      end
      SEG_DECAY: begin
        seg_start = CmpW'(cfg.attack_end);
        seg_den   = cfg.decay_end - cfg.attack_end;
        seg_base  = cfg.peak_level;
        // A decay toward a higher sustain level climbs instead of falling.
        seg_sub   = cfg.peak_level >= cfg.sustain_level;
        seg_a     = seg_sub ? cfg.peak_level - cfg.sustain_level
                            : cfg.sustain_level - cfg.peak_level;
      end
      default: begin
        seg_start = CmpW'(cfg.sustain_end);
        seg_den   = cfg.release_end - cfg.sustain_end;
        seg_base  = cfg.sustain_level;
        seg_sub   = 1'b1;
        seg_a     = cfg.sustain_level;
      end
    endcase
  end

  assign num_full = minute_ext - seg_start;
  assign seg_num  = num_full[END_W-1:0];

  assign md_req.start = md_start;
  assign md_req.a     = seg_a;
  assign md_req.n     = seg_num;
  assign md_req.d     = seg_den;

  always_comb begin
    state_d      = state_q;
    minute_d     = minute_q;
    level_d      = level_q;
    done_d       = done_q;
    rseg_d       = rseg_q;
    base_d       = base_q;
    sub_d        = sub_q;
    md_start     = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_level_d  = out_level_q;
    out_minute_d = out_minute_q;
    out_seg_d    = out_seg_q;
    out_fin_d    = out_fin_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (restart_i) begin
            minute_d = '0;
            level_d  = '0;
            done_d   = 1'b0;
            rseg_d   = SEG_ATTACK;
            state_d  = ST_OUT;
          end else begin
            if (minute_q != {MinuteWidth{1'b1}}) begin
              minute_d = minute_q + MinuteWidth'(1);
            end
            state_d = ST_SEG;
          end
        end
      end
      ST_SEG: begin
        state_d = ST_OUT;
        if (done_q) begin
          rseg_d = SEG_FINISHED;
        end else if (!cfg.envelope_on) begin
          rseg_d = (seg_raw == SEG_FINISHED) ? SEG_RELEASE : seg_raw;
        end else begin
          rseg_d = seg_raw;
          case (seg_raw)
            SEG_FINISHED: begin
              done_d  = 1'b1;
              level_d = '0;
            end
            SEG_SUSTAIN: begin
              level_d = cfg.sustain_level;
            end
            default: begin
              base_d = seg_base;
              sub_d  = seg_sub;
              if (seg_den == '0) begin
                level_d = seg_base;
              end else begin
                md_start = 1'b1;
                state_d  = ST_CALC;
              end
            end
          endcase
        end
      end
      ST_CALC: begin
        if (md_rsp.done) begin
          level_d = sub_q ? base_q - md_rsp.q : base_q + md_rsp.q;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_level_d  = level_q;
          out_minute_d = minute_ext[END_W-1:0];
          out_seg_d    = rseg_q;
          out_fin_d    = done_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      minute_q    <= '0;
      level_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      minute_q    <= minute_d;
      level_q     <= level_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rseg_q       <= rseg_d;
    base_q       <= base_d;
    sub_q        <= sub_d;
    out_level_q  <= out_level_d;
    out_minute_q <= out_minute_d;
    out_seg_q    <= out_seg_d;
    out_fin_q    <= out_fin_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign level_o      = out_level_q;
  assign minute_now_o = out_minute_q;
  assign segment_o    = out_seg_q;
  assign finished_o   = out_fin_q;

  `ADSR_ASSERT_IMP(a_fin_level_zero, clk_i, rst_ni, out_valid_o && finished_o, level_o == '0)
  `ADSR_ASSERT_IMP(a_fin_seg_match, clk_i, rst_ni, out_valid_o, (segment_o == SEG_FINISHED) == finished_o)
  `ADSR_ASSERT_NXT(a_busy_after_beat, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ADSR_ASSERT_IMP(a_calc_only_live, clk_i, rst_ni, state_q == ST_CALC, !done_q && cfg.envelope_on)

endmodule

[bench/tb_adsr_linear_envelope_core.sv]
`timescale 1ns / 100ps

module tb_adsr_linear_envelope_core;
  import adsr_le_pkg::*;

  localparam logic [END_W-1:0] MINUTE_TOP = '1;
  localparam int RANDOM_BEATS = 600;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [END_W-1:0]   minute;
    seg_e               seg;
    logic               finished;
  } envelope_out_t;

  typedef enum logic {DO_WRITE, DO_BEAT} row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    reg_idx_e      idx;
    logic [31:0]   value;
    logic          restart;
    logic          known;
    envelope_out_t want;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  restart_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [LEVEL_W-1:0]    level_o;
  logic [END_W-1:0]      minute_now_o;
  logic [SEG_W-1:0]      segment_o;
  logic                  finished_o;

  // Shadow copy of the block's registers and envelope state.
  cfg_t               env_cfg;
  logic [END_W-1:0]   env_minute;
  logic [LEVEL_W-1:0] env_level;
  logic               env_done;

  envelope_out_t pending_out[$];
  stim_row_t     directed_rows[$];
  int            mismatches;
  int            gap_pct;
  int            stall_pct;
  bit            hold_req;

  adsr_linear_envelope_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .level_o      (level_o),
    .minute_now_o (minute_now_o),
    .segment_o    (segment_o),
    .finished_o   (finished_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [LEVEL_W-1:0] ramp_level(logic [END_W-1:0] m, seg_e sg);
    longint pk, sl, num, den, r;
    pk = longint'(env_cfg.peak_level);
    sl = longint'(env_cfg.sustain_level);
    case (sg)
      SEG_ATTACK: begin
        if (env_cfg.attack_end == 0) return '0;
        r = pk * longint'(m) / longint'(env_cfg.attack_end);
      end
      SEG_DECAY: begin
        num = longint'(m) - longint'(env_cfg.attack_end);
        den = longint'(env_cfg.decay_end) - longint'(env_cfg.attack_end);
        if (den == 0) return env_cfg.peak_level;
        // Signed division truncates toward zero, which matters when the
        // sustain level sits above the peak.
        r = pk - ((pk - sl) * num) / den;
      end
      SEG_SUSTAIN: r = sl;
      default: begin
        num = longint'(m) - longint'(env_cfg.sustain_end);
        den = longint'(env_cfg.release_end) - longint'(env_cfg.sustain_end);
        if (den == 0) return env_cfg.sustain_level;
        r = sl - (sl * num) / den;
      end
    endcase
    if (r < 0) r = 0;
    return r[LEVEL_W-1:0];
  endfunction

  function automatic envelope_out_t advance_envelope(logic rs);
    seg_e          sg;
    envelope_out_t res;
    if (rs) begin
      env_minute = '0;
      env_level  = '0;
      env_done   = 1'b0;
      sg         = SEG_ATTACK;
    end else begin
      if (env_minute != MINUTE_TOP) env_minute++;
      if (env_done) begin
        sg = SEG_FINISHED;
      end else begin
        if (env_minute <= env_cfg.attack_end) sg = SEG_ATTACK;
        else if (env_minute <= env_cfg.decay_end) sg = SEG_DECAY;
        else if (env_minute <= env_cfg.sustain_end) sg = SEG_SUSTAIN;
        else if (env_minute <= env_cfg.release_end) sg = SEG_RELEASE;
        else sg = SEG_FINISHED;
        if (env_cfg.envelope_on) begin
          if (sg == SEG_FINISHED) begin
            env_done  = 1'b1;
            env_level = '0;
          end else begin
            env_level = ramp_level(env_minute, sg);
          end
        end else if (sg == SEG_FINISHED) begin
          // While switched off the flag is never raised.
          sg = SEG_RELEASE;
        end
      end
    end
    res = '{env_level, env_minute, sg, env_done};
    return res;
  endfunction

  function automatic void add_write(reg_idx_e idx, int unsigned value);
    stim_row_t row;
    row = '0;
    row.kind  = DO_WRITE;
    row.idx   = idx;
    row.value = value;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_beat(logic rs);
    stim_row_t row;
    row = '0;
    row.kind    = DO_BEAT;
    row.restart = rs;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_known(logic rs, int lvl, int mn, seg_e sg, logic fin);
    stim_row_t row;
    row = '0;
    row.kind    = DO_BEAT;
    row.restart = rs;
    row.known   = 1'b1;
    row.want    = '{LEVEL_W'(lvl), END_W'(mn), sg, fin};
    directed_rows.push_back(row);
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return LEVEL_W'(1000);
      2: return '1;
      default: return LEVEL_W'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got);
    if (got !== want_v) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want_v, got);
      mismatches++;
    end
  endfunction

  // All driving tasks are entered right after a falling edge and return
  // right after one, having made no assignment in that last step.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << REG_ADDR_LSB;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_ATTACK_END:    env_cfg.attack_end    = value[END_W-1:0];
      REG_DECAY_END:     env_cfg.decay_end     = value[END_W-1:0];
      REG_SUSTAIN_END:   env_cfg.sustain_end   = value[END_W-1:0];
      REG_RELEASE_END:   env_cfg.release_end   = value[END_W-1:0];
      REG_PEAK_LEVEL:    env_cfg.peak_level    = value[LEVEL_W-1:0];
      REG_SUSTAIN_LEVEL: env_cfg.sustain_level = value[LEVEL_W-1:0];
      REG_ENVELOPE_ON:   env_cfg.envelope_on   = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_beat(input logic rs, input logic known, input envelope_out_t want);
    envelope_out_t got;
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    do @(posedge clk_i); while (in_stall_o);
    got = advance_envelope(rs);
    pending_out.push_back(known ? want : got);
    @(negedge clk_i);
  endtask

  task automatic sender_gap(input int n);
    in_valid_i <= 1'b0;
    restart_i  <= 1'($urandom_range(0, 1));
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_out.size() != 0);
  endtask

  always @(posedge clk_i) begin
    envelope_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_out.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual level %0d minute %0d",
                 $time, level_o, minute_now_o);
        mismatches++;
      end else begin
        want = pending_out.pop_front();
        check_field("level", want.level, level_o);
        check_field("minute_now", want.minute, minute_now_o);
        check_field("segment", want.seg, segment_o);
        check_field("finished", want.finished, finished_o);
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    logic [END_W-1:0] e0, e1, e2, e3, top_end;
    logic             rs;
    int               n, mode, random_beats;
    bit               noise, hold_done, pause_done;

    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    restart_i    = 1'b0;
    hold_req     = 1'b0;
    gap_pct      = 10;
    stall_pct    = 10;
    mismatches   = 0;
    random_beats = 0;
    hold_done    = 1'b0;
    pause_done   = 1'b0;
    env_cfg      = CFG_RESET;
    env_minute   = '0;
    env_level    = '0;
    env_done     = 1'b0;

    // With every end at zero, the first tick already lies past release.
    add_known(1'b0, 0, 1, SEG_FINISHED, 1'b1);
    add_known(1'b0, 0, 2, SEG_FINISHED, 1'b1);
    add_known(1'b1, 0, 0, SEG_ATTACK, 1'b0);
    add_write(REG_ATTACK_END, 4);
    add_write(REG_DECAY_END, 8);
    add_write(REG_SUSTAIN_END, 12);
    add_write(REG_RELEASE_END, 16);
    add_write(REG_PEAK_LEVEL, 1000);
    add_write(REG_SUSTAIN_LEVEL, 500);
    repeat (3) add_beat(1'b0);
    add_known(1'b0, 1000, 4, SEG_ATTACK, 1'b0);
    repeat (3) add_beat(1'b0);
    add_known(1'b0, 500, 8, SEG_DECAY, 1'b0);
    add_known(1'b0, 500, 9, SEG_SUSTAIN, 1'b0);
    // Switched off across the sustain/release boundary: level holds.
    add_write(REG_ENVELOPE_ON, 0);
    repeat (5) add_beat(1'b0);
    add_write(REG_ENVELOPE_ON, 1);
    repeat (2) add_beat(1'b0);
    add_known(1'b0, 0, 17, SEG_FINISHED, 1'b1);
    add_known(1'b1, 0, 0, SEG_ATTACK, 1'b0);
    add_write(REG_ATTACK_END, 0);
    add_write(REG_DECAY_END, 0);
    add_write(REG_SUSTAIN_END, 0);
    add_write(REG_RELEASE_END, 0);
    add_write(REG_ENVELOPE_ON, 0);
    add_known(1'b0, 0, 1, SEG_RELEASE, 1'b0);
    add_write(REG_ENVELOPE_ON, 1);
    add_known(1'b0, 0, 2, SEG_FINISHED, 1'b1);
    // Unordered ends: decay and sustain are skipped.
    add_known(1'b1, 0, 0, SEG_ATTACK, 1'b0);
    add_write(REG_ATTACK_END, 5);
    add_write(REG_DECAY_END, 2);
    add_write(REG_SUSTAIN_END, 3);
    add_write(REG_RELEASE_END, 9);
    add_write(REG_PEAK_LEVEL, 1023);
    add_write(REG_SUSTAIN_LEVEL, 0);
    repeat (6) add_beat(1'b0);

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == DO_WRITE) begin
        drain();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
          sender_gap($urandom_range(1, 19));
        send_beat(directed_rows[i].restart, directed_rows[i].known, directed_rows[i].want);
      end
    end

    // The longest possible attack ramp: a full-width divisor gives the
    // smallest steps.
    gap_pct   = 0;
    stall_pct = 0;
    drain();
    write_reg(REG_ATTACK_END, 32'hFFFF);
    write_reg(REG_DECAY_END, 32'hFFFF);
    write_reg(REG_SUSTAIN_END, 32'hFFFF);
    write_reg(REG_RELEASE_END, 32'hFFFF);
    write_reg(REG_PEAK_LEVEL, 1000);
    write_reg(REG_SUSTAIN_LEVEL, 1000);
    write_reg(REG_ENVELOPE_ON, 1);
    send_beat(1'b1, 1'b0, '0);
    repeat (16) send_beat(1'b0, 1'b0, '0);

    while (random_beats < RANDOM_BEATS) begin
      if (random_beats >= RANDOM_BEATS - 120) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      end
      drain();

      mode = $urandom_range(0, 9);
      if (mode < 6 || mode == 9) begin
        e0 = END_W'($urandom_range(0, 8));
        e1 = e0 + END_W'($urandom_range(0, 8));
        e2 = e1 + END_W'($urandom_range(0, 8));
        e3 = (mode == 9) ? MINUTE_TOP : e2 + END_W'($urandom_range(0, 8));
      end else begin
        e0 = END_W'($urandom_range(0, 24));
        e1 = END_W'($urandom_range(0, 24));
        e2 = END_W'($urandom_range(0, 24));
        e3 = END_W'($urandom_range(0, 24));
      end
      write_reg(REG_ATTACK_END, e0);
      write_reg(REG_DECAY_END, e1);
      write_reg(REG_SUSTAIN_END, e2);
      write_reg(REG_RELEASE_END, e3);
      write_reg(REG_PEAK_LEVEL, pick_level());
      write_reg(REG_SUSTAIN_LEVEL, pick_level());
      write_reg(REG_ENVELOPE_ON, ($urandom_range(0, 4) != 0));

      top_end = e0;
      if (e1 > top_end) top_end = e1;
      if (e2 > top_end) top_end = e2;
      if (e3 > top_end) top_end = e3;
      n = int'(top_end) + $urandom_range(1, 6);
      if (n > 60) n = 60;
      noise = ($urandom_range(0, 9) == 0);

      for (int k = 0; k < n; k++) begin
        if (!hold_done && random_beats >= 150) begin
          hold_done = 1'b1;
          hold_req  = 1'b1;
        end
        if (!pause_done && random_beats >= 320) begin
          pause_done = 1'b1;
          drain();
        end
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
          sender_gap($urandom_range(1, 19));
        if (noise) rs = 1'($urandom_range(0, 1));
        else if (k == 0) rs = ($urandom_range(0, 9) < 7);
        else rs = ($urandom_range(0, 24) == 0);
        send_beat(rs, 1'b0, '0);
        random_beats++;
      end
    end

    drain();
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/adsr_le_pkg.sv
hdl/adsr_le_muldiv.sv
hdl/adsr_le_cfg.sv
hdl/adsr_linear_envelope_core.sv
bench/tb_adsr_linear_envelope_core.sv
